[hdl/dbnc_pkg.sv]
// ----------------------------------------------------------------------------
// dbnc_pkg
// shared types and constants for the multi-channel input debouncer
// ----------------------------------------------------------------------------
package dbnc_pkg;

  // bank select carried in req_type
  typedef enum logic [1:0] {
    BANK_FINISH = 2'd0,
    BANK_ALARM  = 2'd1,
    BANK_SIGNAL = 2'd2
  } bank_t;

  // per-channel debounce phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_UP1  = 3'd1,
    PH_UP2  = 3'd2,
    PH_DN1  = 3'd3,
    PH_DN2  = 3'd4,
    PH_DN2A = 3'd5,
    PH_DN1A = 3'd6,
    PH_DN1B = 3'd7
  } phase_t;

  localparam int unsigned ChanWidth = 3;
  localparam int unsigned CodeWidth = 8;

  localparam logic [CodeWidth-1:0] CodeAlarmBase  = 8'h60;
  localparam logic [CodeWidth-1:0] CodeSignalBase = 8'hA0;

  // stored channel state; asserted is the true qualified flag for every bank
  typedef struct packed {
    phase_t phase;
    logic   asserted;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  typedef struct packed {
    bank_t                bank;
    logic [ChanWidth-1:0] channel;
    logic                 level;
    entry_t               entry;
  } step_in_t;

  typedef struct packed {
    entry_t               entry;
    logic                 report_valid;
    logic [CodeWidth-1:0] report_code;
    logic                 flag_level;
  } step_out_t;

endpackage

[hdl/dbnc_if.sv]
// ----------------------------------------------------------------------------
// dbnc request / response channels
// valid-ready channels carrying pin samples in and reports out
// ----------------------------------------------------------------------------
interface dbnc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] channel;
  logic       level;

  modport source (output valid, output req_type, output channel, output level, input ready);
  modport sink   (input valid, input req_type, input channel, input level, output ready);
endinterface

interface dbnc_rsp_if;
  logic       valid;
  logic       ready;
  logic       report_valid;
  logic [7:0] report_code;
  logic       flag_level;

  modport source (output valid, output report_valid, output report_code, output flag_level,
                  input ready);
  modport sink   (input valid, input report_valid, input report_code, input flag_level,
                  output ready);
endinterface

[hdl/dbnc_ram.sv]
// ----------------------------------------------------------------------------
// dbnc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dbnc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 19
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/dbnc_update.sv]
// ----------------------------------------------------------------------------
// dbnc_update
// phase machine step for one channel: next state and report fields
// ----------------------------------------------------------------------------
module dbnc_update (
  input  dbnc_pkg::step_in_t  step_in,
  output dbnc_pkg::step_out_t step_out
);

  logic             act;
  logic             rose;
  logic             fell;
  dbnc_pkg::phase_t ph;
  dbnc_pkg::phase_t ph_next;
  logic             asserted_next;

  assign act = ~step_in.level;
  assign ph  = step_in.entry.phase;

  always_comb begin
    rose    = 1'b0;
    fell    = 1'b0;
    ph_next = ph;
    unique case (ph)
      dbnc_pkg::PH_IDLE: begin
        if (act) ph_next = dbnc_pkg::PH_UP1;
      end
      dbnc_pkg::PH_UP1: begin
        ph_next = act ? dbnc_pkg::PH_UP2 : dbnc_pkg::PH_IDLE;
      end
      dbnc_pkg::PH_UP2: begin
        if (act) begin
          ph_next = dbnc_pkg::PH_DN1;
          rose    = 1'b1;
        end else begin
          ph_next = dbnc_pkg::PH_IDLE;
        end
      end
      dbnc_pkg::PH_DN1: begin
        // signals take the long release path
        if (!act) begin
          ph_next = (step_in.bank == dbnc_pkg::BANK_SIGNAL) ? dbnc_pkg::PH_DN2A
                                                            : dbnc_pkg::PH_DN2;
        end
      end
      dbnc_pkg::PH_DN2: begin
        if (!act) begin
          ph_next = dbnc_pkg::PH_IDLE;
          fell    = 1'b1;
        end else begin
          ph_next = dbnc_pkg::PH_DN1;
        end
      end
      dbnc_pkg::PH_DN2A: begin
        if (!act && step_in.bank == dbnc_pkg::BANK_SIGNAL) ph_next = dbnc_pkg::PH_DN1A;
      end
      dbnc_pkg::PH_DN1A: begin
        if (!act && step_in.bank == dbnc_pkg::BANK_SIGNAL) ph_next = dbnc_pkg::PH_DN1B;
      end
      dbnc_pkg::PH_DN1B: begin
        if (!act && step_in.bank == dbnc_pkg::BANK_SIGNAL) ph_next = dbnc_pkg::PH_DN2;
      end
      default: ph_next = ph;
    endcase
  end

  always_comb begin
    asserted_next = step_in.entry.asserted;
    if (rose) asserted_next = 1'b1;
    if (fell) asserted_next = 1'b0;
  end

  always_comb begin
    step_out.entry.phase    = ph_next;
    step_out.entry.asserted = asserted_next;
    step_out.report_valid   = 1'b0;
    step_out.report_code    = '0;
    step_out.flag_level     = 1'b0;
    unique case (step_in.bank)
      dbnc_pkg::BANK_FINISH: begin
        // finish flag is reported inverted, code once on qualify
        step_out.flag_level   = ~asserted_next;
        step_out.report_valid = rose;
        if (rose) step_out.report_code = dbnc_pkg::CodeWidth'(step_in.channel);
      end
      dbnc_pkg::BANK_ALARM: begin
        step_out.flag_level   = asserted_next;
        step_out.report_valid = asserted_next;
        if (asserted_next) begin
          step_out.report_code = dbnc_pkg::CodeAlarmBase
                               + dbnc_pkg::CodeWidth'(step_in.channel);
        end
      end
      dbnc_pkg::BANK_SIGNAL: begin
        step_out.flag_level   = asserted_next;
        step_out.report_valid = asserted_next;
        if (asserted_next) begin
          step_out.report_code = dbnc_pkg::CodeSignalBase
                               + dbnc_pkg::CodeWidth'(step_in.channel);
        end
      end
      default: begin
        step_out.report_valid = 1'b0;
      end
    endcase
  end

endmodule

[hdl/multi_channel_input_debouncer_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer_unit
// counter-based debounce for axis finish, axis alarm and common signal pins
// ----------------------------------------------------------------------------
//
//  port  dir  payload                                     one request is
//  ----  ---  ------------------------------------------  --------------------
//  req   in   req_type[1:0], channel[2:0], level          one pin sample
//  rsp   out  report_valid, report_code[7:0], flag_level  one result per sample
//
// one request per cycle while req.ready is high; the ram read lands at the
// accept edge; write-back and output load both happen as the stage advances.
// a write-back register forwards the latest entry for back-to-back samples on
// one channel; reset clears the per-entry valid bits at once, no clearing pass.
// an rsp stall holds the update stage; req.ready drops only while the update
// stage and output register are both full and rsp is stalled.
//
module multi_channel_input_debouncer_unit #(
  parameter int unsigned NUM_AXES    = 7,
  parameter int unsigned NUM_SIGNALS = 5
) (
  input  logic      clk,
  input  logic      rst,
  dbnc_req_if.sink  req,
  dbnc_rsp_if.source rsp
);

  // finish bank, then alarm bank, then signal bank
  localparam int unsigned Depth = 2 * NUM_AXES + NUM_SIGNALS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [AW-1:0] AlarmBase  = AW'(NUM_AXES);
  localparam logic [AW-1:0] SignalBase = AW'(2 * NUM_AXES);
  localparam logic [dbnc_pkg::ChanWidth:0] AxisCount   =
    (dbnc_pkg::ChanWidth + 1)'(NUM_AXES);
  localparam logic [dbnc_pkg::ChanWidth:0] SignalCount =
    (dbnc_pkg::ChanWidth + 1)'(NUM_SIGNALS);

  // handshake
  logic accept;
  logic advance;

  // request decode
  dbnc_pkg::bank_t in_bank;
  logic            in_range;
  logic [AW-1:0]   in_addr;
  logic [AW-1:0]   base;

  // update stage
  logic                          s1_valid;
  dbnc_pkg::bank_t               s1_bank;
  logic [dbnc_pkg::ChanWidth-1:0] s1_channel;
  logic                          s1_level;
  logic                          s1_in_range;
  logic [AW-1:0]                 s1_addr;
  logic                          s1_ent_vld;

  // entry valid bits, set on first write
  logic [Depth-1:0] ent_vld;

  // ram and write-back forwarding
  logic [dbnc_pkg::EntryWidth-1:0] ram_rdata;
  logic                            ram_we;
  logic                            fwd_valid;
  logic [AW-1:0]                   fwd_addr;
  dbnc_pkg::entry_t                fwd_data;
  dbnc_pkg::entry_t                cur_entry;

  dbnc_pkg::step_in_t  step_in;
  dbnc_pkg::step_out_t step_out;

  // ---------------------------------------------------------------------------
  // handshake: the update stage moves on whenever the output register frees up
  // ---------------------------------------------------------------------------
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  // ---------------------------------------------------------------------------
  // decode bank and channel into a ram address
  // ---------------------------------------------------------------------------
  assign in_bank = dbnc_pkg::bank_t'(req.req_type);

  always_comb begin
    in_range = 1'b0;
    base     = '0;
    unique case (in_bank)
      dbnc_pkg::BANK_FINISH: begin
        in_range = {1'b0, req.channel} < AxisCount;
        base     = '0;
      end
      dbnc_pkg::BANK_ALARM: begin
        in_range = {1'b0, req.channel} < AxisCount;
        base     = AlarmBase;
      end
      dbnc_pkg::BANK_SIGNAL: begin
        in_range = {1'b0, req.channel} < SignalCount;
        base     = SignalBase;
      end
      default: begin
        // unused bank: out of range, nothing written back
        in_range = 1'b0;
        base     = '0;
      end
    endcase
  end

  assign in_addr = base + AW'(req.channel);

  // ---------------------------------------------------------------------------
  // state memory: read on accept, write back from the update stage
  // ---------------------------------------------------------------------------
  assign ram_we = s1_valid && advance && s1_in_range;

  dbnc_ram #(
    .WIDTH (dbnc_pkg::EntryWidth),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (step_out.entry),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (ram_we) begin
      ent_vld[s1_addr] <= 1'b1;
    end
  end

  // last write-back, used when the ram read raced a write to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= step_out.entry;
    end
  end

  // ---------------------------------------------------------------------------
  // update stage registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bank     <= in_bank;
      s1_channel  <= req.channel;
      s1_level    <= req.level;
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
      s1_ent_vld  <= ent_vld[in_addr];
    end
  end

  // never-written entries read as idle with the flag released
  always_comb begin
    if (fwd_valid && fwd_addr == s1_addr) begin
      cur_entry = fwd_data;
    end else if (s1_ent_vld) begin
      cur_entry = dbnc_pkg::entry_t'(ram_rdata);
    end else begin
      cur_entry.phase    = dbnc_pkg::PH_IDLE;
      cur_entry.asserted = 1'b0;
    end
  end

  assign step_in.bank    = s1_bank;
  assign step_in.channel = s1_channel;
  assign step_in.level   = s1_level;
  assign step_in.entry   = cur_entry;

  dbnc_update u_update (
    .step_in  (step_in),
    .step_out (step_out)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (s1_in_range) begin
        rsp.report_valid <= step_out.report_valid;
        rsp.report_code  <= step_out.report_code;
        rsp.flag_level   <= step_out.flag_level;
      end else begin
        // ignored sample: all fields zero
        rsp.report_valid <= 1'b0;
        rsp.report_code  <= '0;
        rsp.flag_level   <= 1'b0;
      end
    end
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for multi_channel_input_debouncer_unit: pin samples go
// in through the request channel, a local debounce predictor works out each
// report, and every response is compared field by field with the oldest one
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NumAxes    = 7;
  localparam int unsigned NumSignals = 5;
  localparam logic [1:0]  ReqUnused  = 2'd3;   // bank code with no channels
  localparam logic        LvlActive  = 1'b0;   // pins are active low
  localparam logic        LvlIdle    = 1'b1;

  typedef struct packed {
    logic                           report_valid;
    logic [dbnc_pkg::CodeWidth-1:0] report_code;
    logic                           flag_level;
  } report_t;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_ALWAYS = 2'd0,
    RX_RANDOM = 2'd1,
    RX_SPARSE = 2'd2,
    RX_LONG   = 2'd3
  } stall_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dbnc_req_if req_ch ();
  dbnc_rsp_if rsp_ch ();

  multi_channel_input_debouncer_unit #(
    .NUM_AXES   (NumAxes),
    .NUM_SIGNALS(NumSignals)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, one phase and one flag per channel
  dbnc_pkg::phase_t finish_phase [NumAxes];
  dbnc_pkg::phase_t alarm_phase  [NumAxes];
  dbnc_pkg::phase_t signal_phase [NumSignals];
  logic             finish_flag  [NumAxes];     // stored inverted, 0 means asserted
  logic             alarm_flag   [NumAxes];
  logic             signal_flag  [NumSignals];

  report_t pending_reports [$];

  int errors      = 0;
  int n_samples   = 0;
  int n_ignored   = 0;
  int n_checked   = 0;
  int n_coded     = 0;
  int n_qualified = 0;
  int n_released  = 0;
  int burst_left  = 0;

  // one step of a channel's phase machine; signal channels take the long release
  function automatic void debounce_step(input logic is_signal,
                                        inout dbnc_pkg::phase_t ph,
                                        input logic act, output logic rose,
                                        output logic fell);
    rose = 1'b0;
    fell = 1'b0;
    unique case (ph)
      dbnc_pkg::PH_IDLE: if (act) ph = dbnc_pkg::PH_UP1;
      dbnc_pkg::PH_UP1:  ph = act ? dbnc_pkg::PH_UP2 : dbnc_pkg::PH_IDLE;
      dbnc_pkg::PH_UP2: begin
        if (act) begin
          ph   = dbnc_pkg::PH_DN1;
          rose = 1'b1;
        end else begin
          ph = dbnc_pkg::PH_IDLE;
        end
      end
      dbnc_pkg::PH_DN1: if (!act) ph = is_signal ? dbnc_pkg::PH_DN2A : dbnc_pkg::PH_DN2;
      dbnc_pkg::PH_DN2: begin
        if (!act) begin
          ph   = dbnc_pkg::PH_IDLE;
          fell = 1'b1;
        end else begin
          ph = dbnc_pkg::PH_DN1;
        end
      end
      // long release path; active samples here are ignored
      dbnc_pkg::PH_DN2A: if (is_signal && !act) ph = dbnc_pkg::PH_DN1A;
      dbnc_pkg::PH_DN1A: if (is_signal && !act) ph = dbnc_pkg::PH_DN1B;
      dbnc_pkg::PH_DN1B: if (is_signal && !act) ph = dbnc_pkg::PH_DN2;
      default: ;
    endcase
  endfunction

  // apply one accepted sample to the predictor and return its report
  function automatic report_t debounce_report(logic [1:0] bank_code, logic [2:0] ch,
                                              logic level);
    report_t          r;
    dbnc_pkg::phase_t ph;
    logic             act;
    logic             rose;
    logic             fell;
    r   = '0;
    act = (level == LvlActive);
    if (bank_code == dbnc_pkg::BANK_FINISH && ch < NumAxes) begin
      ph = finish_phase[ch];
      debounce_step(1'b0, ph, act, rose, fell);
      finish_phase[ch] = ph;
      if (rose) begin
        finish_flag[ch] = 1'b0;
        r.report_valid  = 1'b1;
        r.report_code   = dbnc_pkg::CodeWidth'(ch);
      end
      if (fell) finish_flag[ch] = 1'b1;
      r.flag_level = finish_flag[ch];
    end else if (bank_code == dbnc_pkg::BANK_ALARM && ch < NumAxes) begin
      ph = alarm_phase[ch];
      debounce_step(1'b0, ph, act, rose, fell);
      alarm_phase[ch] = ph;
      if (rose) alarm_flag[ch] = 1'b1;
      if (fell) alarm_flag[ch] = 1'b0;
      r.flag_level = alarm_flag[ch];
      if (r.flag_level) begin
        r.report_valid = 1'b1;
        r.report_code  = dbnc_pkg::CodeAlarmBase + dbnc_pkg::CodeWidth'(ch);
      end
    end else if (bank_code == dbnc_pkg::BANK_SIGNAL && ch < NumSignals) begin
      ph = signal_phase[ch];
      debounce_step(1'b1, ph, act, rose, fell);
      signal_phase[ch] = ph;
      if (rose) signal_flag[ch] = 1'b1;
      if (fell) signal_flag[ch] = 1'b0;
      r.flag_level = signal_flag[ch];
      if (r.flag_level) begin
        r.report_valid = 1'b1;
        r.report_code  = dbnc_pkg::CodeSignalBase + dbnc_pkg::CodeWidth'(ch);
      end
    end else begin
      n_ignored++;
      rose = 1'b0;
      fell = 1'b0;
    end
    if (rose) n_qualified++;
    if (fell) n_released++;
    return r;
  endfunction

  function automatic logic in_range(logic [1:0] bank_code, logic [2:0] ch);
    return (bank_code == dbnc_pkg::BANK_FINISH || bank_code == dbnc_pkg::BANK_ALARM) ?
             (ch < NumAxes) :
           (bank_code == dbnc_pkg::BANK_SIGNAL) ? (ch < NumSignals) : 1'b0;
  endfunction

  // send one pin sample; called and returns at a falling edge.
  // the sender works in bursts, with idle gaps between them
  task automatic send_sample(logic [1:0] bank_code, logic [2:0] ch, logic level);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= 2'($urandom_range(0, 3));
      req_ch.channel  <= 3'($urandom_range(0, 7));
      req_ch.level    <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                  $urandom_range(1, 8);
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= bank_code;
    req_ch.channel  <= ch;
    req_ch.level    <= level;
    do @(posedge clk); while (!req_ch.ready);
    pending_reports.push_back(debounce_report(bank_code, ch, level));
    n_samples++;
    @(negedge clk);
  endtask

  task automatic send_levels(logic [1:0] bank_code, logic [2:0] ch, int count,
                             logic level);
    repeat (count) send_sample(bank_code, ch, level);
  endtask

  // finish bank: assert on the highest axis, report once, then release
  task automatic test_finish_bank();
    send_levels(dbnc_pkg::BANK_FINISH, 3'd6, 3, LvlActive);
    send_levels(dbnc_pkg::BANK_FINISH, 3'd6, 2, LvlIdle);
  endtask

  // alarm bank: report on every sample while set, including the first release one
  task automatic test_alarm_bank();
    send_levels(dbnc_pkg::BANK_ALARM, 3'd0, 3, LvlActive);
    send_levels(dbnc_pkg::BANK_ALARM, 3'd0, 2, LvlIdle);
  endtask

  // signal bank: ignored active mid-release, active at the last step, full release
  task automatic test_signal_bank();
    send_levels(dbnc_pkg::BANK_SIGNAL, 3'd4, 3, LvlActive);
    send_levels(dbnc_pkg::BANK_SIGNAL, 3'd4, 1, LvlIdle);
    send_levels(dbnc_pkg::BANK_SIGNAL, 3'd4, 1, LvlActive);
    send_levels(dbnc_pkg::BANK_SIGNAL, 3'd4, 3, LvlIdle);
    send_levels(dbnc_pkg::BANK_SIGNAL, 3'd4, 1, LvlActive);
    send_levels(dbnc_pkg::BANK_SIGNAL, 3'd4, 5, LvlIdle);
  endtask

  // unused bank code and channels past the bank count
  task automatic test_ignored_requests();
    send_sample(ReqUnused, 3'd2, LvlActive);
    send_sample(dbnc_pkg::BANK_FINISH, 3'd7, LvlActive);
    send_sample(dbnc_pkg::BANK_SIGNAL, 3'd5, LvlActive);
  endtask

  // per-channel runs of one level with occasional flips and noise, interleaved
  // across channels, with many back-to-back samples on one channel
  task automatic test_random_traffic(int target);
    logic       run_level [32];
    logic [1:0] b;
    logic [2:0] ch;
    logic       lvl;
    int         pick;
    int         counted;
    b       = dbnc_pkg::BANK_FINISH;
    ch      = 3'd0;
    counted = 0;
    foreach (run_level[i]) run_level[i] = LvlIdle;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick >= 40 && pick < 92) begin
        b  = 2'($urandom_range(0, 2));
        ch = 3'($urandom_range(0, (b == dbnc_pkg::BANK_SIGNAL) ? NumSignals - 1 :
                                                                  NumAxes - 1));
      end else if (pick >= 92) begin
        b  = 2'($urandom_range(0, 3));
        ch = 3'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 3) == 0) run_level[{b, ch}] = ~run_level[{b, ch}];
      lvl = ($urandom_range(0, 11) == 0) ? 1'($urandom_range(0, 1)) : run_level[{b, ch}];
      send_sample(b, ch, lvl);
      if (in_range(b, ch)) counted++;
    end
  endtask

  // receiver stalls, style changes every window
  stall_style_t stall_style  = RX_ALWAYS;
  int           stall_window = 0;
  logic [31:0]  stall_cycle  = '0;

  always @(negedge clk) begin
    if (stall_window == 0) begin
      stall_style  = stall_style_t'($urandom_range(0, 3));
      stall_window = $urandom_range(40, 200);
    end else begin
      stall_window--;
    end
    stall_cycle++;
    unique case (stall_style)
      RX_ALWAYS: rsp_ch.ready <= 1'b1;
      RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: rsp_ch.ready <= (stall_cycle[1:0] == 2'd0);
      default:   rsp_ch.ready <= (stall_cycle[4:0] >= 5'd24);
    endcase
  end

  // response checker
  always @(posedge clk) begin
    report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ERROR: unexpected response, expected none, got valid=%0b code=%0h flag=%0b",
                 $time, rsp_ch.report_valid, rsp_ch.report_code, rsp_ch.flag_level);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        if (want.report_valid) n_coded++;
        if (rsp_ch.report_valid !== want.report_valid) begin
          $display("%0t ERROR: report_valid expected %0b, got %0b",
                   $time, want.report_valid, rsp_ch.report_valid);
          errors++;
        end
        if (rsp_ch.report_code !== want.report_code) begin
          $display("%0t ERROR: report_code expected %02h, got %02h",
                   $time, want.report_code, rsp_ch.report_code);
          errors++;
        end
        if (rsp_ch.flag_level !== want.flag_level) begin
          $display("%0t ERROR: flag_level expected %0b, got %0b",
                   $time, want.flag_level, rsp_ch.flag_level);
          errors++;
        end
      end
    end
  end

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.req_type = 2'd0;
    req_ch.channel  = 3'd0;
    req_ch.level    = LvlIdle;
    rsp_ch.ready    = 1'b0;
    foreach (finish_phase[i]) begin
      finish_phase[i] = dbnc_pkg::PH_IDLE;
      alarm_phase[i]  = dbnc_pkg::PH_IDLE;
      finish_flag[i]  = 1'b1;
      alarm_flag[i]   = 1'b0;
    end
    foreach (signal_phase[i]) begin
      signal_phase[i] = dbnc_pkg::PH_IDLE;
      signal_flag[i]  = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_finish_bank();
    test_alarm_bank();
    test_signal_bank();
    test_ignored_requests();
    test_random_traffic(1300 - n_samples);

    req_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d samples sent (%0d ignored), %0d responses checked, %0d with a code",
             n_samples, n_ignored, n_checked, n_coded);
    $display("run: %0d flag qualify events and %0d release events across all banks",
             n_qualified, n_released);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t ERROR: timeout with %0d responses outstanding", $time,
             pending_reports.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
